// ----- sv/ptm_pkg.sv -----
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants and types of the page table map and translate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

  // Default number of page entries in the store.
  localparam int unsigned PAGE_COUNT_DEF = 4096;

  // Address split of a 4 KiB page.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned FRAME_W  = ADDR_W - OFFSET_W;

  // Field widths of the item channels.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned FLAGS_W  = 12;

  // Flag bits that init writes into every entry.
  localparam int unsigned INIT_FLAGS_W = 8;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT       = 3'd0,
    CMD_MAP        = 3'd1,
    CMD_MAP_RANGE  = 3'd2,
    CMD_MAP_TO_END = 3'd3,
    CMD_GET        = 3'd4,
    CMD_TRANSLATE  = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_RANGE      = 2'd2
  } status_t;

endpackage : ptm_pkg

`default_nettype wire

// ----- sv/page_table_map_translate_engine_top.sv -----
// ----------------------------------------------------------------------------
// page_table_map_translate_engine_top
// Page table engine: a flat store of 32-bit page entries with init, map,
// range map, get and translate commands, one result item per command item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   command, addresses, count, flags
//   out_     output     out_valid / out_ready status, read_value, pages_written
//
// One item is worked on at a time, with the entry store as a single RAM that
// takes one access per cycle. Map, unused commands and any command rejected
// on acceptance load the result slot directly; get and translate load it
// from the registered RAM read in the read state. Init writes one entry per
// cycle after the acceptance; map_range and map_to_end write their pages in
// turn. Reset clears only control state: the store holds no defined value
// until init has run, so no clearing pass follows it.
// A new item is taken while the previous result is being handed over.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_map_translate_engine_top
  import ptm_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [ADDR_W-1:0]   in_virt_address,
  input  wire logic [ADDR_W-1:0]   in_phys_address,
  input  wire logic [ADDR_W-1:0]   in_phys_end_address,
  input  wire logic [COUNT_W-1:0]  in_page_count,
  input  wire logic [FLAGS_W-1:0]  in_entry_flags,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [ADDR_W-1:0]        out_read_value,
  output logic [COUNT_W-1:0]       out_pages_written
);

  localparam int unsigned AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [AW-1:0]      LAST_IDX   = AW'(PAGE_COUNT - 1);
  localparam logic [COUNT_W-1:0] PAGE_TOTAL = COUNT_W'(PAGE_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_RUN,
    S_READ
  } state_t;

  // Control and loop registers.
  state_t               state_r, state_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [FLAGS_W-1:0]   flags_r, flags_nxt;
  logic [FRAME_W-1:0]   vpage_r, vpage_nxt;
  logic [FRAME_W-1:0]   pframe_r, pframe_nxt;
  logic [FRAME_W-1:0]   eframe_r, eframe_nxt;
  logic [COUNT_W-1:0]   remain_r, remain_nxt;
  logic [COUNT_W-1:0]   written_r, written_nxt;
  logic                 to_end_r, to_end_nxt;
  logic                 xlate_r, xlate_nxt;
  logic [OFFSET_W-1:0]  offset_r, offset_nxt;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]    out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]   out_written_r, out_written_nxt;

  // Memory port signals.
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ADDR_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [ADDR_W-1:0]    mem_rdata;

  // Result produced this cycle.
  logic                 res_load;
  status_t              res_status;
  logic [ADDR_W-1:0]    res_value;
  logic [COUNT_W-1:0]   res_written;

  // Decode of the incoming item.
  logic                 in_fire;
  logic [FRAME_W-1:0]   in_vpage;
  logic                 in_v_ok, in_p_ok, in_e_ok, in_v_in;
  logic                 run_v_in, run_done;

  ptm_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (PAGE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // A new item is taken when idle and the result slot is free or freeing.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign in_vpage = in_virt_address[ADDR_W-1:OFFSET_W];
  assign in_v_ok  = (in_virt_address[OFFSET_W-1:0] == '0);
  assign in_p_ok  = (in_phys_address[OFFSET_W-1:0] == '0);
  assign in_e_ok  = (in_phys_end_address[OFFSET_W-1:0] == '0);
  assign in_v_in  = ({1'b0, in_vpage} < PAGE_TOTAL);

  // Range loop: stop when the count or the physical end is reached, or when the virtual page leaves the table.
  assign run_v_in = ({1'b0, vpage_r} < PAGE_TOTAL);
  assign run_done = to_end_r ? !(pframe_r < eframe_r) : (remain_r == '0);

  // Command sequencer and memory access.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    flags_nxt   = flags_r;
    vpage_nxt   = vpage_r;
    pframe_nxt  = pframe_r;
    eframe_nxt  = eframe_r;
    remain_nxt  = remain_r;
    written_nxt = written_r;
    to_end_nxt  = to_end_r;
    xlate_nxt   = xlate_r;
    offset_nxt  = offset_r;

    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    res_load    = 1'b0;
    res_status  = ST_OK;
    res_value   = '0;
    res_written = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(in_command))
            CMD_INIT: begin
              idx_nxt   = '0;
              flags_nxt = in_entry_flags;
              state_nxt = S_INIT;
            end
            CMD_MAP: begin
              res_load = 1'b1;
              if (!in_v_ok || !in_p_ok) begin
                res_status = ST_MISALIGNED;
              end else if (!in_v_in) begin
                res_status = ST_RANGE;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = in_vpage[AW-1:0];
                mem_wdata   = {in_phys_address[ADDR_W-1:OFFSET_W], in_entry_flags};
                res_written = COUNT_W'(1);
              end
            end
            CMD_MAP_RANGE, CMD_MAP_TO_END: begin
              if ((cmd_t'(in_command) == CMD_MAP_RANGE) && (in_page_count == '0)) begin
                res_load = 1'b1;
              end else if (!in_v_ok || !in_p_ok ||
                           ((cmd_t'(in_command) == CMD_MAP_TO_END) && !in_e_ok)) begin
                res_load   = 1'b1;
                res_status = ST_MISALIGNED;
              end else begin
                vpage_nxt   = in_vpage;
                pframe_nxt  = in_phys_address[ADDR_W-1:OFFSET_W];
                eframe_nxt  = in_phys_end_address[ADDR_W-1:OFFSET_W];
                remain_nxt  = in_page_count;
                written_nxt = '0;
                flags_nxt   = in_entry_flags;
                to_end_nxt  = (cmd_t'(in_command) == CMD_MAP_TO_END);
                state_nxt   = S_RUN;
              end
            end
            CMD_GET: begin
              if (!in_v_ok) begin
                res_load   = 1'b1;
                res_status = ST_MISALIGNED;
              end else if (!in_v_in) begin
                res_load   = 1'b1;
                res_status = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_vpage[AW-1:0];
                xlate_nxt = 1'b0;
                state_nxt = S_READ;
              end
            end
            CMD_TRANSLATE: begin
              if (!in_v_in) begin
                res_load   = 1'b1;
                res_status = ST_RANGE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = in_vpage[AW-1:0];
                xlate_nxt  = 1'b1;
                offset_nxt = in_virt_address[OFFSET_W-1:0];
                state_nxt  = S_READ;
              end
            end
            default: begin
              // Unused command codes change nothing.
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_INIT: begin
        // Identity mapping, one entry per cycle.
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = {FRAME_W'(idx_r), {(OFFSET_W-INIT_FLAGS_W){1'b0}},
                     flags_r[INIT_FLAGS_W-1:0]};
        if (idx_r == LAST_IDX) begin
          res_load    = 1'b1;
          res_written = PAGE_TOTAL;
          state_nxt   = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_RUN: begin
        if (run_done) begin
          res_load    = 1'b1;
          res_written = written_r;
          state_nxt   = S_IDLE;
        end else if (!run_v_in) begin
          res_load    = 1'b1;
          res_status  = ST_RANGE;
          res_written = written_r;
          state_nxt   = S_IDLE;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = vpage_r[AW-1:0];
          mem_wdata   = {pframe_r, flags_r};
          vpage_nxt   = vpage_r + FRAME_W'(1);
          pframe_nxt  = pframe_r + FRAME_W'(1);
          remain_nxt  = remain_r - COUNT_W'(1);
          written_nxt = written_r + COUNT_W'(1);
        end
      end

      S_READ: begin
        res_load  = 1'b1;
        res_value = xlate_r ? {mem_rdata[ADDR_W-1:OFFSET_W], offset_r} : mem_rdata;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result slot: loaded when a command finishes, freed when taken.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_value_nxt   = out_value_r;
    out_written_nxt = out_written_r;
    if (res_load) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = res_status;
      out_value_nxt   = res_value;
      out_written_nxt = res_written;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    flags_r       <= flags_nxt;
    vpage_r       <= vpage_nxt;
    pframe_r      <= pframe_nxt;
    eframe_r      <= eframe_nxt;
    remain_r      <= remain_nxt;
    written_r     <= written_nxt;
    to_end_r      <= to_end_nxt;
    xlate_r       <= xlate_nxt;
    offset_r      <= offset_nxt;
    out_status_r  <= out_status_nxt;
    out_value_r   <= out_value_nxt;
    out_written_r <= out_written_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_value_r;
  assign out_pages_written = out_written_r;

endmodule : page_table_map_translate_engine_top

`default_nettype wire

// ----- sv/ptm_ram.sv -----
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data appears on rdata in the cycle after the read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : ptm_ram

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page table map and translate engine. A shadow
// copy of the entry store predicts every result item; results are checked
// field by field, in order, against the queue of predicted outcomes. The
// stimulus starts with init, walks the alignment, range-stop and wrap
// corners, then runs a random command mix with idling on both channels.
// ----------------------------------------------------------------------------

module tb_top
  import ptm_pkg::*;
();

  localparam int unsigned TB_PAGES    = PAGE_COUNT_DEF;
  localparam bit [31:0]   PAGE_STEP   = 32'h0000_1000;
  localparam bit [31:0]   FRAME_MASK  = 32'hFFFF_F000;
  localparam bit [11:0]   OFFSET_MASK = 12'hFFF;
  localparam bit [20:0]   COUNT_TOP   = 21'h10_0000;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned TAIL_CYCLES  = 50;

  // Command codes that the block ignores.
  localparam bit [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam bit [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // One predicted result item.
  typedef struct {
    status_t         status;
    bit [ADDR_W-1:0] read_value;
    bit [COUNT_W-1:0] pages_written;
  } ptm_outcome_t;

  // Shadow of the entry store with the queue of predicted outcomes.
  class page_table_shadow;
    bit [ADDR_W-1:0] entries [TB_PAGES];
    ptm_outcome_t    awaited_results [$];
    int unsigned     mismatch_count;
    int unsigned     results_checked;
    int unsigned     error_outcomes;
    int unsigned     cmd_seen [8];

    task flag_error(string msg);
      $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // Writes one entry; both addresses are known to be aligned here.
    function status_t write_entry(bit [31:0] virt, bit [31:0] phys, bit [11:0] flags);
      if ((virt >> OFFSET_W) >= TB_PAGES) return ST_RANGE;
      entries[virt >> OFFSET_W] = phys | {20'h0, flags};
      return ST_OK;
    endfunction

    // Predicts the outcome of one accepted command and updates the shadow.
    function void apply_command(bit [2:0] cmd, bit [31:0] virt, bit [31:0] phys,
                                bit [31:0] pend, bit [20:0] count, bit [11:0] flags);
      ptm_outcome_t res;
      int unsigned  n;
      res.status        = ST_OK;
      res.read_value    = '0;
      res.pages_written = '0;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_INIT: begin
          for (n = 0; n < TB_PAGES; n++)
            entries[n] = (n << OFFSET_W) | {24'h0, flags[INIT_FLAGS_W-1:0]};
          res.pages_written = COUNT_W'(TB_PAGES);
        end
        CMD_MAP: begin
          if (virt[11:0] != 0 || phys[11:0] != 0) begin
            res.status = ST_MISALIGNED;
          end else begin
            res.status = write_entry(virt, phys, flags);
            if (res.status == ST_OK) res.pages_written = 21'd1;
          end
        end
        CMD_MAP_RANGE: begin
          // A zero count wins over the alignment check.
          if (count != 0) begin
            if (virt[11:0] != 0 || phys[11:0] != 0) begin
              res.status = ST_MISALIGNED;
            end else begin
              for (n = 0; n < count; n++) begin
                res.status = write_entry(virt, phys, flags);
                if (res.status != ST_OK) break;
                res.pages_written++;
                virt += PAGE_STEP;
                phys += PAGE_STEP;
              end
            end
          end
        end
        CMD_MAP_TO_END: begin
          if (virt[11:0] != 0 || phys[11:0] != 0 || pend[11:0] != 0) begin
            res.status = ST_MISALIGNED;
          end else begin
            while (phys < pend) begin
              res.status = write_entry(virt, phys, flags);
              if (res.status != ST_OK) break;
              res.pages_written++;
              virt += PAGE_STEP;
              phys += PAGE_STEP;
            end
          end
        end
        CMD_GET: begin
          if (virt[11:0] != 0) res.status = ST_MISALIGNED;
          else if ((virt >> OFFSET_W) >= TB_PAGES) res.status = ST_RANGE;
          else res.read_value = entries[virt >> OFFSET_W];
        end
        CMD_TRANSLATE: begin
          // Translate takes any offset within the page.
          if ((virt >> OFFSET_W) >= TB_PAGES) res.status = ST_RANGE;
          else res.read_value = (entries[virt >> OFFSET_W] & FRAME_MASK) |
                                {20'h0, virt[11:0]};
        end
        default: begin
        end
      endcase
      if (res.status != ST_OK) error_outcomes++;
      awaited_results.push_back(res);
    endfunction

    // Compares one result item with the oldest prediction.
    task check_result(logic [1:0] status, logic [31:0] read_value,
                      logic [20:0] pages_written);
      ptm_outcome_t want;
      if (awaited_results.size() == 0) begin
        flag_error("result item with nothing predicted");
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      if (status !== want.status)
        flag_error($sformatf("status %0d, predicted %0d", status, want.status));
      if (read_value !== want.read_value)
        flag_error($sformatf("read_value %08h, predicted %08h",
                             read_value, want.read_value));
      if (pages_written !== want.pages_written)
        flag_error($sformatf("pages_written %0d, predicted %0d",
                             pages_written, want.pages_written));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command;
  logic [ADDR_W-1:0]   in_virt_address;
  logic [ADDR_W-1:0]   in_phys_address;
  logic [ADDR_W-1:0]   in_phys_end_address;
  logic [COUNT_W-1:0]  in_page_count;
  logic [FLAGS_W-1:0]  in_entry_flags;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_read_value;
  logic [COUNT_W-1:0]  out_pages_written;

  // Set for a long stretch of items during which neither side idles.
  bit steady_phase;

  page_table_shadow shadow_tbl = new();

  page_table_map_translate_engine_top #(
    .PAGE_COUNT(TB_PAGES)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_virt_address     (in_virt_address),
    .in_phys_address     (in_phys_address),
    .in_phys_end_address (in_phys_end_address),
    .in_page_count       (in_page_count),
    .in_entry_flags      (in_entry_flags),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_read_value      (out_read_value),
    .out_pages_written   (out_pages_written)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit. The slowest legal run of this stimulus, with every command
  // taking a full table pass and the receiver stalling, stays well below it.
  initial begin
    #40_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady_phase || ($urandom_range(0, 99) >= 34);
  end

  // Both channels are sampled at the edge: accepted commands go into the
  // shadow first, then any accepted result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        shadow_tbl.apply_command(in_command, in_virt_address, in_phys_address,
                                 in_phys_end_address, in_page_count, in_entry_flags);
      if (out_valid && out_ready)
        shadow_tbl.check_result(out_status, out_read_value, out_pages_written);
    end
  end

  // Presents one command item, after a random idle gap outside the steady
  // stretch, and waits until the block takes it.
  task automatic send_command(bit [2:0] cmd, bit [31:0] virt, bit [31:0] phys,
                              bit [31:0] pend, bit [20:0] count, bit [11:0] flags);
    if (!steady_phase) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_virt_address     <= virt;
    in_phys_address     <= phys;
    in_phys_end_address <= pend;
    in_page_count       <= count;
    in_entry_flags      <= flags;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender back until every predicted result has come out. It first
  // waits for a clock edge so that the last accepted item is already predicted.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow_tbl.awaited_results.size() != 0) @(posedge clk);
  endtask

  // One random command. Most addresses fall inside the table and are page
  // aligned so that writes land; the rest probe the error paths.
  task automatic send_random_command();
    int unsigned roll;
    bit [2:0]    cmd;
    bit [31:0]   virt;
    bit [31:0]   phys;
    bit [31:0]   pend;
    bit [20:0]   count;
    bit [11:0]   flags;

    roll = $urandom_range(0, 99);
    if (roll < 1)       cmd = CMD_INIT;
    else if (roll < 23) cmd = CMD_MAP;
    else if (roll < 38) cmd = CMD_MAP_RANGE;
    else if (roll < 50) cmd = CMD_MAP_TO_END;
    else if (roll < 72) cmd = CMD_GET;
    else if (roll < 94) cmd = CMD_TRANSLATE;
    else if (roll < 97) cmd = CMD_SPARE_A;
    else                cmd = CMD_SPARE_B;

    roll = $urandom_range(0, 99);
    if (roll < 70)
      virt = 32'($urandom_range(0, TB_PAGES - 1)) << OFFSET_W;
    else if (roll < 80)
      virt = 32'(TB_PAGES - 1 - $urandom_range(0, 5)) << OFFSET_W;
    else if (roll < 90)
      virt = (32'($urandom_range(0, TB_PAGES - 1)) << OFFSET_W) |
             32'($urandom_range(1, OFFSET_MASK));
    else
      virt = $urandom();
    if (cmd == CMD_TRANSLATE && $urandom_range(0, 1) == 1)
      virt[11:0] = 12'($urandom());

    phys = ($urandom_range(0, 99) < 80) ? ($urandom() & FRAME_MASK) : $urandom();

    // Short spans mostly; a few run until the table edge stops them.
    roll = $urandom_range(0, 99);
    if (roll < 75)      pend = phys + (32'($urandom_range(0, 8)) << OFFSET_W);
    else if (roll < 85) pend = $urandom() & FRAME_MASK;
    else if (roll < 95) pend = phys + 32'($urandom_range(1, 3 * OFFSET_MASK));
    else                pend = $urandom();

    roll = $urandom_range(0, 99);
    if (roll < 70)      count = 21'($urandom_range(0, 8));
    else if (roll < 88) count = 21'($urandom_range(0, 64));
    else if (roll < 97) count = 21'($urandom_range(0, COUNT_TOP));
    else                count = COUNT_TOP;

    flags = 12'($urandom());
    send_command(cmd, virt, phys, pend, count, flags);
  endtask

  // Main sequence.
  initial begin
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_command          <= '0;
    in_virt_address     <= '0;
    in_phys_address     <= '0;
    in_phys_end_address <= '0;
    in_page_count       <= '0;
    in_entry_flags      <= '0;
    out_ready           <= 1'b0;
    steady_phase        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners. Init runs first so that no read hits an unwritten
    // entry; only the low eight flag bits must reach the entries.
    send_command(CMD_INIT,       32'h0000_0000, 32'h0, 32'h0, 21'd0, 12'hFFF);
    send_command(CMD_GET,        32'h0000_0000, 32'h0, 32'h0, 21'd0, 12'h0);
    send_command(CMD_TRANSLATE,  32'h0000_0FFF, 32'h0, 32'h0, 21'd0, 12'h0);
    send_command(CMD_MAP,        32'h0000_1000, 32'hFFFF_F000, 32'h0, 21'd0, 12'hFFF);
    send_command(CMD_GET,        32'h0000_1000, 32'h0, 32'h0, 21'd0, 12'h0);
    send_command(CMD_TRANSLATE,  32'h0000_1ABC, 32'h0, 32'h0, 21'd0, 12'h0);
    // Misaligned virtual and physical addresses, then pages past the table.
    send_command(CMD_MAP,        32'h0000_2001, 32'h0000_3000, 32'h0, 21'd0, 12'h1);
    send_command(CMD_MAP,        32'h0000_2000, 32'h0000_3800, 32'h0, 21'd0, 12'h1);
    send_command(CMD_MAP,        32'h0100_0000, 32'h0000_3000, 32'h0, 21'd0, 12'h1);
    send_command(CMD_MAP,        32'hFFFF_F000, 32'h0000_3000, 32'h0, 21'd0, 12'h1);
    // Range map: zero count beats misalignment, misalignment stops it early,
    // the table edge stops it part way, and the physical address wraps.
    send_command(CMD_MAP_RANGE,  32'h0000_0123, 32'h0000_0456, 32'h0, 21'd0, 12'h2);
    send_command(CMD_MAP_RANGE,  32'h0000_5000, 32'h0000_0456, 32'h0, 21'd3, 12'h2);
    send_command(CMD_MAP_RANGE,  32'h00FF_E000, 32'h1234_5000, 32'h0, 21'd5, 12'h0A5);
    send_command(CMD_MAP_RANGE,  32'h0000_A000, 32'hFFFF_E000, 32'h0, 21'd4, 12'h3C3);
    send_command(CMD_MAP_RANGE,  32'hFFFF_F000, 32'h0000_0000, 32'h0, COUNT_TOP, 12'h7);
    // Map to end: empty span, misaligned end, table edge, plain span.
    send_command(CMD_MAP_TO_END, 32'h0000_4000, 32'h0002_0000, 32'h0002_0000, 21'd0, 12'h8);
    send_command(CMD_MAP_TO_END, 32'h0000_4000, 32'h0002_0000, 32'h0003_0010, 21'd0, 12'h8);
    send_command(CMD_MAP_TO_END, 32'h00FF_D000, 32'h0000_0000, 32'h0001_0000, 21'd0, 12'h5A5);
    send_command(CMD_MAP_TO_END, 32'h0000_4000, 32'h8000_0000, 32'h8000_4000, 21'd0, 12'h800);
    // Get with a misaligned address, get past the table, translate past it.
    send_command(CMD_GET,        32'hFFFF_FFFF, 32'h0, 32'h0, 21'd0, 12'h0);
    send_command(CMD_GET,        32'h0100_0000, 32'h0, 32'h0, 21'd0, 12'h0);
    send_command(CMD_TRANSLATE,  32'hFFFF_FFFF, 32'h0, 32'h0, 21'd0, 12'h0);
    send_command(CMD_SPARE_A,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'h1F_FFFF, 12'hFFF);
    send_command(CMD_SPARE_B,    32'h0000_1000, 32'h0000_2000, 32'h0, 21'd1, 12'h0);
    send_command(CMD_INIT,       32'h0, 32'h0, 32'h0, 21'd0, 12'h05A);
    send_command(CMD_GET,        32'h00FF_F000, 32'h0, 32'h0, 21'd0, 12'h0);
    send_command(CMD_TRANSLATE,  32'h00FF_FFFF, 32'h0, 32'h0, 21'd0, 12'h0);

    // Let the block empty out before the random part.
    wait_for_drain();

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      steady_phase = (k >= 150 && k < 260);
      send_random_command();
    end
    steady_phase = 1'b0;

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d init, %0d map, %0d range, %0d to-end, %0d get, %0d translate,",
             shadow_tbl.cmd_seen[CMD_INIT], shadow_tbl.cmd_seen[CMD_MAP],
             shadow_tbl.cmd_seen[CMD_MAP_RANGE], shadow_tbl.cmd_seen[CMD_MAP_TO_END],
             shadow_tbl.cmd_seen[CMD_GET], shadow_tbl.cmd_seen[CMD_TRANSLATE]);
    $display("tb_top: %0d unused commands; %0d results checked, %0d with an error status",
             shadow_tbl.cmd_seen[CMD_SPARE_A] + shadow_tbl.cmd_seen[CMD_SPARE_B],
             shadow_tbl.results_checked, shadow_tbl.error_outcomes);
    if (shadow_tbl.mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
